### rtl/arp_address_table_assert.svh
// Assertion macros shared by the address table checks.
`ifndef ARP_ADDRESS_TABLE_ASSERT_SVH
`define ARP_ADDRESS_TABLE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define AAT_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define AAT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define AAT_ASSERT_ALWAYS(label, pre, post, msg) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/aat_pkg.sv
// Shared types and constants of the ARP address table.
package aat_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int OP_W     = 2;
   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 5;

   localparam logic [COUNT_W-1:0] COUNT_FULL     = COUNT_W'(TABLE_ENTRIES);
   localparam logic [USED_W-1:0]  USED_WHEN_FULL = USED_W'(TABLE_ENTRIES);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // Request class, one-hot.
   typedef struct packed {
      logic is_insert;
      logic is_lookup;
      logic is_delete;
      logic is_clear;
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } item_type;

   // Back end to table: apply one request using a registered match vector.
   typedef struct packed {
      logic                     apply;
      kind_type                 kind;
      logic [IP_W-1:0]          ip;
      logic [MAC_W-1:0]         mac;
      logic [TABLE_ENTRIES-1:0] hit;
   } upd_type;

   // Table to back end: outcome of the pending request.
   typedef struct packed {
      logic               hit_any;
      logic               full;
      logic [MAC_W-1:0]   found_mac;
      logic [COUNT_W-1:0] count_next;
   } tbl_stat_type;

endpackage

### rtl/aat_if.sv
// Request and response channel interfaces of the ARP address table.
interface aat_req_if;
   logic                        valid;
   logic                        ready;
   logic [aat_pkg::OP_W-1:0]    operation;
   logic [aat_pkg::IP_W-1:0]    ip_address;
   logic [aat_pkg::MAC_W-1:0]   mac_address;

   modport source (output valid, operation, ip_address, mac_address, input ready);
   modport sink   (input valid, operation, ip_address, mac_address, output ready);
endinterface

interface aat_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [aat_pkg::STATUS_W-1:0]  status;
   logic [aat_pkg::MAC_W-1:0]     found_mac;
   logic [aat_pkg::USED_W-1:0]    entries_used;

   modport source (output valid, status, found_mac, entries_used, input ready);
   modport sink   (input valid, status, found_mac, entries_used, output ready);
endinterface

### rtl/aat_front.sv
// Front end: accepts requests, classifies them and queues them.
module aat_front (
   input  logic              clock,
   input  logic              reset,
   aat_req_if.sink           req_if,
   output aat_pkg::item_type q_item,
   output logic              q_valid,
   input  logic              q_pop
);

   localparam int PW = aat_pkg::QPTR_W;
   localparam int FW = aat_pkg::QFILL_W;

   aat_pkg::item_type slot_ff [aat_pkg::QUEUE_DEPTH];
   aat_pkg::item_type slot_in [aat_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]     fill_ff, fill_in;
   aat_pkg::item_type new_item;
   aat_pkg::op_type   op;
   logic              push;
   logic              pop;

   assign op = aat_pkg::op_type'(req_if.operation);

   always_comb begin
      new_item.kind.is_insert = (op == aat_pkg::OP_INSERT);
      new_item.kind.is_lookup = (op == aat_pkg::OP_LOOKUP);
      new_item.kind.is_delete = (op == aat_pkg::OP_DELETE);
      new_item.kind.is_clear  = (op == aat_pkg::OP_CLEAR);
      new_item.ip             = req_if.ip_address;
      new_item.mac            = req_if.mac_address;
   end

   assign req_if.ready = (fill_ff != FW'(aat_pkg::QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign q_valid      = (fill_ff != '0);
   assign pop          = q_pop && q_valid;
   assign q_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      for (int i = 0; i < aat_pkg::QUEUE_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (push) begin
         slot_in[wr_ptr_ff] = new_item;
      end
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < aat_pkg::QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/aat_table.sv
// Packed table of address pairs: parallel key compare, append, update, shift-down delete and clear.
module aat_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [aat_pkg::IP_W-1:0]           search_ip,
   output logic [aat_pkg::TABLE_ENTRIES-1:0]  search_hit,
   input  aat_pkg::upd_type                   upd,
   output aat_pkg::tbl_stat_type              stat
);

   localparam int N  = aat_pkg::TABLE_ENTRIES;
   localparam int CW = aat_pkg::COUNT_W;

   logic [aat_pkg::IP_W-1:0]  key_ff [N];
   logic [aat_pkg::IP_W-1:0]  key_in [N];
   logic [aat_pkg::MAC_W-1:0] mac_ff [N];
   logic [aat_pkg::MAC_W-1:0] mac_in [N];
   logic [aat_pkg::IP_W-1:0]  key_above [N];
   logic [aat_pkg::MAC_W-1:0] mac_above [N];
   logic [CW-1:0]             count_ff, count_in;
   logic [N-1:0]              at_or_past;

   // Neighbour taps for the shift-down on delete.
   for (genvar gi = 0; gi < N; gi++) begin : g_tap
      if (gi < N - 1) begin : g_next
         assign key_above[gi] = key_ff[gi+1];
         assign mac_above[gi] = mac_ff[gi+1];
      end else begin : g_last
         assign key_above[gi] = key_ff[gi];
         assign mac_above[gi] = mac_ff[gi];
      end
   end

   // Only slots below the count take part in a match.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         search_hit[i] = (CW'(i) < count_ff) && (key_ff[i] == search_ip);
      end
   end

   // Slots from the matching one upward.
   always_comb begin
      logic run;
      run = 1'b0;
      for (int i = 0; i < N; i++) begin
         run           = run | upd.hit[i];
         at_or_past[i] = run;
      end
   end

   always_comb begin
      stat.hit_any   = |upd.hit;
      stat.full      = (count_ff >= aat_pkg::COUNT_FULL);
      stat.found_mac = '0;
      for (int i = 0; i < N; i++) begin
         if (upd.hit[i]) begin
            stat.found_mac = stat.found_mac | mac_ff[i];
         end
      end
      stat.count_next = count_ff;
      if (upd.kind.is_insert && !stat.hit_any && !stat.full) begin
         stat.count_next = count_ff + CW'(1);
      end else if (upd.kind.is_delete && stat.hit_any) begin
         stat.count_next = count_ff - CW'(1);
      end else if (upd.kind.is_clear) begin
         stat.count_next = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         key_in[i] = key_ff[i];
         mac_in[i] = mac_ff[i];
         if (upd.apply && upd.kind.is_insert) begin
            if (upd.hit[i]) begin
               mac_in[i] = upd.mac;
            end else if (!stat.hit_any && !stat.full && count_ff == CW'(i)) begin
               key_in[i] = upd.ip;
               mac_in[i] = upd.mac;
            end
         end else if (upd.apply && upd.kind.is_delete && at_or_past[i]) begin
            key_in[i] = key_above[i];
            mac_in[i] = mac_above[i];
         end
      end
      count_in = upd.apply ? stat.count_next : count_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         key_ff[i] <= key_in[i];
         mac_ff[i] <= mac_in[i];
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/aat_back.sv
// Back end: search then apply sequencer and the response register.
module aat_back (
   input  logic                               clock,
   input  logic                               reset,
   input  aat_pkg::item_type                  q_item,
   input  logic                               q_valid,
   output logic                               q_pop,
   output logic [aat_pkg::IP_W-1:0]           search_ip,
   input  logic [aat_pkg::TABLE_ENTRIES-1:0]  search_hit,
   output aat_pkg::upd_type                   upd,
   input  aat_pkg::tbl_stat_type              stat,
   aat_rsp_if.source                          rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   aat_pkg::item_type                 work_ff, work_in;
   logic [aat_pkg::TABLE_ENTRIES-1:0] hit_ff, hit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   aat_pkg::status_type               status_ff, status_in;
   logic [aat_pkg::MAC_W-1:0]         found_ff, found_in;
   logic [aat_pkg::USED_W-1:0]        used_ff, used_in;
   logic                              out_free;
   logic                              apply;

   assign search_ip = q_item.ip;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      hit_in       = hit_ff;
      q_pop        = 1'b0;
      apply        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      found_in     = found_ff;
      used_in      = used_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               work_in  = q_item;
               hit_in   = search_hit;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               apply        = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = aat_pkg::STATUS_OK;
               found_in     = '0;
               if (work_ff.kind.is_insert) begin
                  if (!stat.hit_any && stat.full) begin
                     status_in = aat_pkg::STATUS_FULL;
                  end
               end else if (work_ff.kind.is_lookup) begin
                  if (stat.hit_any) begin
                     found_in = stat.found_mac;
                  end else begin
                     status_in = aat_pkg::STATUS_NOT_FOUND;
                  end
               end else if (work_ff.kind.is_delete) begin
                  if (!stat.hit_any) begin
                     status_in = aat_pkg::STATUS_NOT_FOUND;
                  end
               end
               used_in  = aat_pkg::USED_W'(stat.count_next);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      upd.apply = apply;
      upd.kind  = work_ff.kind;
      upd.ip    = work_ff.ip;
      upd.mac   = work_ff.mac;
      upd.hit   = hit_ff;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.found_mac    = found_ff;
   assign rsp_if.entries_used = used_ff;

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      used_ff   <= used_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/arp_address_table.sv
// Top level of the ARP address table: IPv4 to MAC mapping with insert, lookup, delete, clear.
//
// Channels: req_if carries one request per item (operation, ip_address, mac_address);
// rsp_if returns exactly one response item per request (status, found_mac, entries_used),
// in request order. Both use valid/ready; an item moves when both are high at a clock edge.
// A taken request passes through the queue, the back end's work and match registers and
// the response register. The back end takes one request at a time: in its idle state it
// compares the key against every slot in parallel, and in its apply state, once the response
// register is free, it applies the update, append or shift-down and loads that register.
// A two-item queue sits between the front and the back end, so requests are still taken
// while a response waits; once the queue fills, req_if.ready drops.
// If rsp_if.ready is low, the response holds in its register and the back end waits
// with its next request.
// Reset (synchronous, active high) empties the queue and the table count and drops
// rsp_if.valid; key and MAC slots are not cleared, since slots at or above the count are
// never read.
module arp_address_table (
   input  logic       clock,
   input  logic       reset,
   aat_req_if.sink    req_if,
   aat_rsp_if.source  rsp_if
);

   aat_pkg::item_type                 q_item;
   logic                              q_valid;
   logic                              q_pop;
   logic [aat_pkg::IP_W-1:0]          search_ip;
   logic [aat_pkg::TABLE_ENTRIES-1:0] search_hit;
   aat_pkg::upd_type                  upd;
   aat_pkg::tbl_stat_type             stat;

   // Request intake and classification.
   aat_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // Storage, compare and table updates.
   aat_table u_table (
      .clock      (clock),
      .reset      (reset),
      .search_ip  (search_ip),
      .search_hit (search_hit),
      .upd        (upd),
      .stat       (stat)
   );

   // Sequencing and response register.
   aat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .search_ip  (search_ip),
      .search_hit (search_hit),
      .upd        (upd),
      .stat       (stat),
      .rsp_if     (rsp_if)
   );

endmodule

### rtl/aat_checker.sv
// Port-level checks on the ARP address table, bound to the top level.
`include "arp_address_table_assert.svh"

module aat_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [aat_pkg::STATUS_W-1:0]  rsp_status,
   input logic [aat_pkg::MAC_W-1:0]     rsp_found_mac,
   input logic [aat_pkg::USED_W-1:0]    rsp_entries_used
);

   `AAT_ASSERT_NOW(a_full_means_all_used, rsp_valid && rsp_status == aat_pkg::STATUS_FULL, rsp_entries_used == aat_pkg::USED_WHEN_FULL, "table full reported with free slots")

   `AAT_ASSERT_NOW(a_mac_only_on_success, rsp_valid && rsp_status != aat_pkg::STATUS_OK, rsp_found_mac == '0, "MAC returned with a failing status")

   `AAT_ASSERT_ALWAYS(a_quiet_after_reset, reset, !rsp_valid, "response valid right after reset")

   `AAT_ASSERT_NEXT(a_stalled_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_mac) && $stable(rsp_entries_used), "stalled response changed")

endmodule

bind arp_address_table aat_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_found_mac    (rsp_if.found_mac),
   .rsp_entries_used (rsp_if.entries_used)
);
